FILE: rtl/wmir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wmir_pkg;

  localparam int DATA_W    = 64;
  localparam int WID_W     = 7;
  localparam int DIV_STEPS = DATA_W;
  localparam int MAX_WIDTH_DEF = 64;

  // Operation class
  localparam logic [1:0] CLS_BIN  = 2'd0;
  localparam logic [1:0] CLS_UNA  = 2'd1;
  localparam logic [1:0] CLS_CMP  = 2'd2;
  localparam logic [1:0] CLS_CAST = 2'd3;

  // Binary ops
  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_UDIV = 4'd3;
  localparam logic [3:0] OP_SDIV = 4'd4;
  localparam logic [3:0] OP_UREM = 4'd5;
  localparam logic [3:0] OP_SREM = 4'd6;
  localparam logic [3:0] OP_AND  = 4'd7;
  localparam logic [3:0] OP_OR   = 4'd8;
  localparam logic [3:0] OP_XOR  = 4'd9;
  localparam logic [3:0] OP_SHL  = 4'd10;
  localparam logic [3:0] OP_LSHR = 4'd11;
  localparam logic [3:0] OP_ASHR = 4'd12;
  localparam logic [3:0] OP_ROL  = 4'd13;
  localparam logic [3:0] OP_ROR  = 4'd14;

  // Unary ops
  localparam logic [3:0] UN_NEG = 4'd0;
  localparam logic [3:0] UN_COM = 4'd1;
  localparam logic [3:0] UN_NOT = 4'd2;

  // Compare predicates
  localparam logic [3:0] CMP_EQ  = 4'd0;
  localparam logic [3:0] CMP_NE  = 4'd1;
  localparam logic [3:0] CMP_ULT = 4'd2;
  localparam logic [3:0] CMP_ULE = 4'd3;
  localparam logic [3:0] CMP_UGT = 4'd4;
  localparam logic [3:0] CMP_UGE = 4'd5;
  localparam logic [3:0] CMP_SLT = 4'd6;
  localparam logic [3:0] CMP_SLE = 4'd7;
  localparam logic [3:0] CMP_SGT = 4'd8;
  localparam logic [3:0] CMP_SGE = 4'd9;

  // Casts
  localparam logic [3:0] CV_TRUNC = 4'd0;
  localparam logic [3:0] CV_ZEXT  = 4'd1;
  localparam logic [3:0] CV_SEXT  = 4'd2;

  // How the last stage forms the result
  typedef enum logic [2:0] {
    K_PLAIN,
    K_MUL,
    K_QUO,
    K_REM,
    K_ROL,
    K_ROR
  } kind_t;

  // Payload carried through the divider stages
  typedef struct packed {
    kind_t              kind;
    logic               neg;
    logic               dz;
    logic [WID_W-1:0]   w;
    logic [DATA_W-1:0]  ua;
    logic [DATA_W-1:0]  r;
    logic [DATA_W-1:0]  rem;
    logic [DATA_W-1:0]  quo;
    logic [DATA_W-1:0]  den;
  } div_t;

  function automatic logic [DATA_W-1:0] mask_to(input logic [DATA_W-1:0] v,
                                                input logic [WID_W-1:0] w);
    logic [DATA_W-1:0] m;
    m = {DATA_W{1'b1}} >> (WID_W'(DATA_W) - w);
    return v & m;
  endfunction

  function automatic logic [DATA_W-1:0] sign_ext(input logic [DATA_W-1:0] v,
                                                 input logic [WID_W-1:0] w);
    logic [DATA_W-1:0] m;
    m = {{(DATA_W-1){1'b0}}, 1'b1} << (w - WID_W'(1));
    return (mask_to(v, w) ^ m) - m;
  endfunction

  function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (DATA_W'(0) - v) : v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/width_masked_ir_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: operand stage, decode stage,
// multiply-sum stage, 64 divider stages, result stage.
// Throughput: one item per cycle; the 64-step restoring divider is fully pipelined.
// Stall: the whole pipeline holds while the output register is full and not taken.
// Reset: synchronous; clears all valid bits, payload registers are not reset.
module width_masked_ir_alu
  import wmir_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        req_type,
  input  wire logic [3:0]        sub_op,
  input  wire logic [DATA_W-1:0] operand_a,
  input  wire logic [DATA_W-1:0] operand_b,
  input  wire logic [WID_W-1:0]  op_width,
  input  wire logic [WID_W-1:0]  source_width,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DATA_W-1:0]      result
);

  // Global advance: every stage moves when the output register can take an item.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------------------------------------------------------------------
  // Stage A: clamp widths, reduce operands to the operation width.
  // ---------------------------------------------------------------------------
  logic [WID_W-1:0] w_in, sw_in;

  always_comb begin
    if (op_width == '0) begin
      w_in = WID_W'(1);
    end else if (op_width > WID_W'(MAX_WIDTH)) begin
      w_in = WID_W'(MAX_WIDTH);
    end else begin
      w_in = op_width;
    end
    if (source_width == '0) begin
      sw_in = WID_W'(1);
    end else if (source_width > WID_W'(MAX_WIDTH)) begin
      sw_in = WID_W'(MAX_WIDTH);
    end else begin
      sw_in = source_width;
    end
  end

  logic              a_vld;
  logic [1:0]        a_cls;
  logic [3:0]        a_op;
  logic [WID_W-1:0]  a_w;
  logic [DATA_W-1:0] a_ua, a_ub, a_sa, a_sb, a_b, a_ca, a_cs;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
    if (en) begin
      a_cls <= req_type;
      a_op  <= sub_op;
      a_w   <= w_in;
      a_ua  <= mask_to(operand_a, w_in);
      a_ub  <= mask_to(operand_b, w_in);
      a_sa  <= sign_ext(operand_a, w_in);
      a_sb  <= sign_ext(operand_b, w_in);
      a_b   <= operand_b;
      a_ca  <= mask_to(operand_a, sw_in);
      a_cs  <= sign_ext(operand_a, sw_in);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: simple ops, multiply partial products, divider setup.
  // ---------------------------------------------------------------------------
  logic [5:0]        sh;
  logic [DATA_W-1:0] r_next, num_next, den_next;
  kind_t             kind_next;
  logic              neg_next;

  assign sh = a_b[5:0];

  always_comb begin
    r_next    = '0;
    kind_next = K_PLAIN;
    num_next  = a_ua;
    den_next  = a_ub;
    neg_next  = 1'b0;
    case (a_cls)
      CLS_BIN: begin
        case (a_op) inside
          OP_ADD:  r_next = a_ua + a_ub;
          OP_SUB:  r_next = a_ua - a_ub;
          OP_MUL:  kind_next = K_MUL;
          OP_UDIV: kind_next = K_QUO;
          OP_UREM: kind_next = K_REM;
          OP_SDIV: begin
            kind_next = K_QUO;
            num_next  = magnitude(a_sa);
            den_next  = magnitude(a_sb);
            neg_next  = a_sa[DATA_W-1] ^ a_sb[DATA_W-1];
          end
          OP_SREM: begin
            kind_next = K_REM;
            num_next  = magnitude(a_sa);
            den_next  = magnitude(a_sb);
            neg_next  = a_sa[DATA_W-1];
          end
          OP_AND:  r_next = a_ua & a_ub;
          OP_OR:   r_next = a_ua | a_ub;
          OP_XOR:  r_next = a_ua ^ a_ub;
          OP_SHL:  r_next = a_ua << sh;
          OP_LSHR: r_next = a_ua >> sh;
          OP_ASHR: r_next = DATA_W'($signed(a_sa) >>> sh);
          OP_ROL, OP_ROR: begin
            // rotate amount is operand_b mod width: let the divider find it
            kind_next = (a_op == OP_ROL) ? K_ROL : K_ROR;
            num_next  = a_b;
            den_next  = DATA_W'(a_w);
          end
          default: r_next = '0;
        endcase
      end
      CLS_UNA: begin
        case (a_op)
          UN_NEG:  r_next = DATA_W'(0) - a_ua;
          UN_COM:  r_next = ~a_ua;
          UN_NOT:  r_next = DATA_W'(a_ua == '0);
          default: r_next = '0;
        endcase
      end
      CLS_CMP: begin
        case (a_op)
          CMP_EQ:  r_next = DATA_W'(a_ua == a_ub);
          CMP_NE:  r_next = DATA_W'(a_ua != a_ub);
          CMP_ULT: r_next = DATA_W'(a_ua <  a_ub);
          CMP_ULE: r_next = DATA_W'(a_ua <= a_ub);
          CMP_UGT: r_next = DATA_W'(a_ua >  a_ub);
          CMP_UGE: r_next = DATA_W'(a_ua >= a_ub);
          CMP_SLT: r_next = DATA_W'($signed(a_sa) <  $signed(a_sb));
          CMP_SLE: r_next = DATA_W'($signed(a_sa) <= $signed(a_sb));
          CMP_SGT: r_next = DATA_W'($signed(a_sa) >  $signed(a_sb));
          CMP_SGE: r_next = DATA_W'($signed(a_sa) >= $signed(a_sb));
          default: r_next = '0;
        endcase
      end
      default: begin
        case (a_op) inside
          CV_TRUNC, CV_ZEXT: r_next = a_ca;
          CV_SEXT:           r_next = a_cs;
          default:           r_next = '0;
        endcase
      end
    endcase
  end

  localparam int HALF = DATA_W / 2;

  logic              b_vld;
  kind_t             b_kind;
  logic              b_neg, b_dz;
  logic [WID_W-1:0]  b_w;
  logic [DATA_W-1:0] b_ua, b_r, b_num, b_den, b_pll;
  logic [HALF-1:0]   b_plh, b_phl;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
    if (en) begin
      b_kind <= kind_next;
      b_neg  <= neg_next;
      b_dz   <= (den_next == '0);
      b_w    <= a_w;
      b_ua   <= a_ua;
      b_r    <= r_next;
      b_num  <= num_next;
      b_den  <= den_next;
      // low half of the product only needs three 32x32 partials
      b_pll  <= a_ua[HALF-1:0] * a_ub[HALF-1:0];
      b_plh  <= HALF'(a_ua[HALF-1:0] * a_ub[DATA_W-1:HALF]);
      b_phl  <= HALF'(a_ua[DATA_W-1:HALF] * a_ub[HALF-1:0]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: finish the multiply, load the divider.
  // ---------------------------------------------------------------------------
  div_t            d [DIV_STEPS+1];
  logic [DIV_STEPS:0] d_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld[0] <= 1'b0;
    end else if (en) begin
      d_vld[0] <= b_vld;
    end
    if (en) begin
      d[0].kind <= b_kind;
      d[0].neg  <= b_neg;
      d[0].dz   <= b_dz;
      d[0].w    <= b_w;
      d[0].ua   <= b_ua;
      d[0].r    <= (b_kind == K_MUL) ? (b_pll + {b_plh + b_phl, {HALF{1'b0}}}) : b_r;
      d[0].rem  <= '0;
      d[0].quo  <= b_num;
      d[0].den  <= b_den;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: one restoring step per stage; quotient bits shift in from the right.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [DATA_W:0] trial;
    logic            fits;
    div_t            nxt;

    always_comb begin
      trial = {d[i].rem, d[i].quo[DATA_W-1]};
      fits  = trial >= {1'b0, d[i].den};
      nxt   = d[i];
      nxt.rem = fits ? DATA_W'(trial - {1'b0, d[i].den}) : trial[DATA_W-1:0];
      nxt.quo = {d[i].quo[DATA_W-2:0], fits};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_vld[i+1] <= 1'b0;
      end else if (en) begin
        d_vld[i+1] <= d_vld[i];
      end
      if (en) begin
        d[i+1] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result stage: sign fix, rotate, final mask.
  // ---------------------------------------------------------------------------
  div_t              fin;
  logic [WID_W-1:0]  rot, rot_back;
  logic [DATA_W-1:0] res_next;

  assign fin      = d[DIV_STEPS];
  assign rot      = fin.rem[WID_W-1:0];
  assign rot_back = fin.w - rot;

  always_comb begin
    case (fin.kind)
      K_QUO: res_next = fin.dz ? '0 : (fin.neg ? DATA_W'(0) - fin.quo : fin.quo);
      K_REM: res_next = fin.dz ? '0 : (fin.neg ? DATA_W'(0) - fin.rem : fin.rem);
      K_ROL: res_next = (rot == '0) ? fin.ua : ((fin.ua << rot) | (fin.ua >> rot_back));
      K_ROR: res_next = (rot == '0) ? fin.ua : ((fin.ua >> rot) | (fin.ua << rot_back));
      default: res_next = fin.r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_vld[DIV_STEPS];
    end
    if (en) begin
      result <= mask_to(res_next, fin.w);
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_rst_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (d_vld[DIV_STEPS] && fin.den != '0) |-> (fin.rem < fin.den))
    else $error("divider remainder not below divisor");

  a_rot_below_w: assert property (@(posedge clk) disable iff (rst)
    (d_vld[DIV_STEPS] && (fin.kind == K_ROL || fin.kind == K_ROR))
      |-> (DATA_W'(rot) < DATA_W'(fin.w)))
    else $error("rotate amount not reduced below width");

endmodule
`default_nettype wire

FILE: bench/width_masked_ir_alu_tb.sv
`timescale 1ns / 1ps
module width_masked_ir_alu_tb;
  import wmir_pkg::*;

  localparam int LATENCY    = 68;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1850;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = '0;
  logic [3:0]  sub_op = '0;
  logic [63:0] operand_a = '0;
  logic [63:0] operand_b = '0;
  logic [6:0]  op_width = 7'd1;
  logic [6:0]  source_width = 7'd1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] result;

  // Percent of cycles in which each side holds off.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  logic [63:0] expected_results[$];
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  always #5 clk = ~clk;

  width_masked_ir_alu i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .sub_op       (sub_op),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .op_width     (op_width),
    .source_width (source_width),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result       (result)
  );

  // ---------------------------------------------------------------
  // Result predictor
  // ---------------------------------------------------------------
  function automatic logic [63:0] low_bits(logic [63:0] v, int unsigned w);
    if (w >= 64) return v;
    return v & ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [63:0] widen_signed(logic [63:0] v, int unsigned w);
    logic [63:0] top;
    if (w >= 64) return v;
    top = 64'd1 << (w - 1);
    return (low_bits(v, w) ^ top) - top;
  endfunction

  function automatic int unsigned fix_width(logic [6:0] w);
    if (w == 0) return 1;
    if (w > 64) return 64;
    return 32'(w);
  endfunction

  function automatic logic [63:0] abs64(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic [63:0] alu_result(logic [1:0] cls, logic [3:0] op,
                                             logic [63:0] a, logic [63:0] b,
                                             logic [6:0] wf, logic [6:0] swf);
    int unsigned w, sw;
    logic [63:0] ua, ub, sa, sb, q, r, rot;
    logic        t;
    int unsigned sh;
    w  = fix_width(wf);
    sw = fix_width(swf);
    ua = low_bits(a, w);
    ub = low_bits(b, w);
    sa = widen_signed(a, w);
    sb = widen_signed(b, w);
    sh = 32'(b[5:0]);
    r  = '0;
    t  = 1'b0;
    case (cls)
      CLS_BIN: begin
        rot = b % w;
        case (op)
          OP_ADD:  r = ua + ub;
          OP_SUB:  r = ua - ub;
          OP_MUL:  r = ua * ub;
          OP_UDIV: r = (ub != 0) ? ua / ub : '0;
          OP_SDIV: if (ub != 0) begin
            q = abs64(sa) / abs64(sb);
            r = (sa[63] != sb[63]) ? -q : q;
          end
          OP_UREM: r = (ub != 0) ? ua % ub : '0;
          OP_SREM: if (ub != 0) begin
            q = abs64(sa) % abs64(sb);
            r = sa[63] ? -q : q;
          end
          OP_AND:  r = ua & ub;
          OP_OR:   r = ua | ub;
          OP_XOR:  r = ua ^ ub;
          OP_SHL:  r = ua << sh;
          OP_LSHR: r = ua >> sh;
          OP_ASHR: r = $signed(sa) >>> sh;
          OP_ROL:  r = (rot == 0) ? ua : ((ua << rot) | (ua >> (w - rot)));
          OP_ROR:  r = (rot == 0) ? ua : ((ua >> rot) | (ua << (w - rot)));
          default: r = '0;
        endcase
        r = low_bits(r, w);
      end
      CLS_UNA: begin
        case (op)
          UN_NEG:  r = low_bits(-a, w);
          UN_COM:  r = low_bits(~a, w);
          UN_NOT:  r = (ua == 0) ? 64'd1 : 64'd0;
          default: r = '0;
        endcase
      end
      CLS_CMP: begin
        case (op)
          CMP_EQ:  t = ua == ub;
          CMP_NE:  t = ua != ub;
          CMP_ULT: t = ua < ub;
          CMP_ULE: t = ua <= ub;
          CMP_UGT: t = ua > ub;
          CMP_UGE: t = ua >= ub;
          CMP_SLT: t = $signed(sa) < $signed(sb);
          CMP_SLE: t = $signed(sa) <= $signed(sb);
          CMP_SGT: t = $signed(sa) > $signed(sb);
          CMP_SGE: t = $signed(sa) >= $signed(sb);
          default: t = 1'b0;
        endcase
        r = {63'd0, t};
      end
      default: begin
        case (op) inside
          CV_TRUNC, CV_ZEXT: r = low_bits(low_bits(a, sw), w);
          CV_SEXT:           r = low_bits(widen_signed(a, sw), w);
          default:           r = '0;
        endcase
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------
  typedef struct {
    logic [1:0]  cls;
    logic [3:0]  op;
    logic [63:0] a;
    logic [63:0] b;
    logic [6:0]  w;
    logic [6:0]  sw;
    bit          typed;   // expected value written in the row
    logic [63:0] value;
  } alu_row_t;

  // Present one item, hold it until taken, queue its expected result.
  task automatic send_item(alu_row_t it);
    logic [63:0] exp_value;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= it.cls;
    sub_op       <= it.op;
    operand_a    <= it.a;
    operand_b    <= it.b;
    op_width     <= it.w;
    source_width <= it.sw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_value = it.typed ? it.value
        : alu_result(it.cls, it.op, it.a, it.b, it.w, it.sw);
    expected_results = {expected_results, exp_value};
  endtask

  // Pick an operand biased toward edge values (zero, all ones, one set bit, low byte).
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(5, 0))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63, 0);
      3: return {32'd0, $urandom} & 64'hff;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [6:0] pick_width();
    case ($urandom_range(9, 0))
      0: return 7'd64;
      1: return 7'd1;
      2: return 7'($urandom_range(127, 0));   // out of range too
      default: return 7'($urandom_range(64, 1));
    endcase
  endfunction

  alu_row_t directed_rows[27] = '{
    '{CLS_BIN,  OP_ADD,  '1, 64'd1, 7'd64, 7'd1, 1'b1, 64'd0},
    '{CLS_BIN,  OP_SUB,  '0, 64'd1, 7'd8,  7'd1, 1'b1, 64'hff},
    '{CLS_BIN,  OP_MUL,  '1, '1,    7'd64, 7'd1, 1'b0, '0},
    '{CLS_BIN,  OP_UDIV, 64'd7, '0, 7'd64, 7'd1, 1'b1, 64'd0},
    '{CLS_BIN,  OP_SDIV, 64'h80, 64'hff, 7'd8, 7'd1, 1'b1, 64'h80},
    '{CLS_BIN,  OP_SDIV, 64'hf9, 64'd2, 7'd8, 7'd1, 1'b0, '0},
    '{CLS_BIN,  OP_UREM, 64'd9, 64'h100, 7'd8, 7'd1, 1'b1, 64'd0},
    '{CLS_BIN,  OP_SREM, 64'h80, 64'hff, 7'd8, 7'd1, 1'b1, 64'd0},
    '{CLS_BIN,  OP_SREM, 64'hf9, 64'd2, 7'd8, 7'd1, 1'b0, '0},
    '{CLS_BIN,  OP_AND,  '1, 64'h5a, 7'd0, 7'd1, 1'b1, 64'd0},
    '{CLS_BIN,  OP_OR,   '0, '1, 7'd127, 7'd1, 1'b1, '1},
    '{CLS_BIN,  OP_XOR,  '1, 64'h0f, 7'd4, 7'd1, 1'b1, 64'd0},
    '{CLS_BIN,  OP_SHL,  64'd1, 64'd8, 7'd8, 7'd1, 1'b1, 64'd0},
    '{CLS_BIN,  OP_LSHR, '1, 64'd127, 7'd64, 7'd1, 1'b1, 64'd1},
    '{CLS_BIN,  OP_ASHR, 64'h80, 64'd40, 7'd8, 7'd1, 1'b1, 64'hff},
    '{CLS_BIN,  OP_ROL,  64'h81, 64'd8, 7'd8, 7'd1, 1'b1, 64'h81},
    '{CLS_BIN,  OP_ROR,  64'h01, 64'd65, 7'd64, 7'd1, 1'b1, 64'h8000_0000_0000_0000},
    '{CLS_BIN,  4'd15,   '1, '1, 7'd64, 7'd1, 1'b1, 64'd0},
    '{CLS_UNA,  UN_NEG,  64'd1, '0, 7'd16, 7'd1, 1'b1, 64'hffff},
    '{CLS_UNA,  UN_COM,  '0, '0, 7'd64, 7'd1, 1'b1, '1},
    '{CLS_UNA,  UN_NOT,  64'h100, '0, 7'd8, 7'd1, 1'b1, 64'd1},
    '{CLS_UNA,  4'd3,    '1, '0, 7'd64, 7'd1, 1'b1, 64'd0},
    '{CLS_CMP,  CMP_SLT, 64'h80, 64'h7f, 7'd8, 7'd1, 1'b1, 64'd1},
    '{CLS_CMP,  4'd12,   '0, '0, 7'd8, 7'd1, 1'b1, 64'd0},
    '{CLS_CAST, CV_SEXT, 64'h80, '0, 7'd16, 7'd8, 1'b1, 64'hff80},
    '{CLS_CAST, CV_TRUNC, '1, '0, 7'd64, 7'd0, 1'b1, 64'd1},
    '{CLS_CAST, 4'd3,    '1, '0, 7'd64, 7'd64, 1'b1, 64'd0}
  };

  // ---------------------------------------------------------------
  // Checking, receiver stalls and watchdog
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          error_count++;
        end else begin
          if (result !== expected_results[0]) begin
            $display("%0t: result expected %h actual %h", $time,
                     expected_results[0], result);
            error_count++;
          end
          void'(expected_results.pop_front());
        end
      end
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("width_masked_ir_alu test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------
  initial begin
    alu_row_t it;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows with light sender idling and heavy receiver stalls.
    send_idle_pct = 10;
    recv_idle_pct = 81;
    foreach (directed_rows[i]) send_item(directed_rows[i]);

    // Random items; idling pattern changes by thirds.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 81;
        recv_idle_pct = 10;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      it.cls   = 2'($urandom_range(3, 0));
      it.op    = ($urandom_range(15, 0) == 0) ? 4'($urandom_range(15, 0))
               : (it.cls == CLS_BIN) ? 4'($urandom_range(14, 0))
               : (it.cls == CLS_UNA) ? 4'($urandom_range(2, 0))
               : (it.cls == CLS_CMP) ? 4'($urandom_range(9, 0))
               : 4'($urandom_range(2, 0));
      it.a     = pick_operand();
      it.b     = ($urandom_range(3, 0) == 0) ? it.a : pick_operand();
      it.w     = pick_width();
      it.sw    = pick_width();
      it.typed = 1'b0;
      it.value = '0;
      send_item(it);
    end
    in_valid <= 1'b0;

    // Drain, then let the pipeline settle for any stray output.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("width_masked_ir_alu test passed");
    end else begin
      $display("width_masked_ir_alu test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/wmir_pkg.sv
rtl/width_masked_ir_alu.sv
bench/width_masked_ir_alu_tb.sv
